FILE: hdl/wrm_pkg.sv
// shared types and constants of the windowed rmse error map
`default_nettype none
package wrm_pkg;

    localparam int COL_W  = 11;
    localparam int ROW_W  = 13;
    localparam int POS_W  = 24;
    localparam int CHN_W  = 3;
    localparam int SQ_W   = 16;
    localparam int RMSE_W = 16;

    // depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // configuration register map
    localparam int APB_ADDR_W = 4;
    localparam logic [1:0] REG_WIDTH    = 2'd0;
    localparam logic [1:0] REG_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_CHANNELS = 2'd2;

    // reciprocal for the divide by three of the channel average
    localparam int THIRD_DIV   = 3;
    localparam int THIRD_SHIFT = 20;
    localparam int THIRD_MUL   = ((1 << THIRD_SHIFT) + THIRD_DIV - 1) / THIRD_DIV;
    localparam int THIRD_W     = THIRD_SHIFT + 1;

    // effective frame configuration
    typedef struct packed {
        logic [COL_W-1:0] width;
        logic [ROW_W-1:0] height;
        logic [CHN_W-1:0] chans;
        logic [POS_W-1:0] total;
        logic [POS_W-1:0] delay;
    } wrm_cfg_t;

    // one classified request for the back part
    typedef struct packed {
        logic             restart;
        logic             emit;
        logic             last;
        logic [ROW_W-1:0] in_row;
        logic [COL_W-1:0] in_col;
        logic [ROW_W-1:0] out_row;
        logic [COL_W-1:0] out_col;
    } wrm_cmd_t;

endpackage
`default_nettype wire

FILE: hdl/wrm_ram.sv
// generic single write port ram with registered read
`default_nettype none
module wrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

FILE: hdl/wrm_queue.sv
// short command queue between front and back part
`default_nettype none
module wrm_queue import wrm_pkg::*; #(
    parameter int DW = 64
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire wrm_cmd_t push_cmd,
    input  wire logic [DW-1:0] push_data,
    output logic          full,
    input  wire logic     pop,
    output logic          empty,
    output wrm_cmd_t      head_cmd,
    output logic [DW-1:0] head_data
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    wrm_cmd_t        cmd_mem [QUEUE_DEPTH];
    logic [DW-1:0]   data_mem [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW:0]     count_reg;

    assign full      = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign head_cmd  = cmd_mem[rd_ptr_reg];
    assign head_data = data_mem[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            cmd_mem[wr_ptr_reg]  <= push_cmd;
            data_mem[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (PW+1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (PW+1)'(1);
            end
        end
    end

endmodule
`default_nettype wire

FILE: hdl/wrm_front.sv
// front part: frame position tracking and request classification
`default_nettype none
module wrm_front import wrm_pkg::*; #(
    parameter int MAX_CHANNELS = 4
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire wrm_cfg_t        cfg,
    input  wire logic            cfg_wr,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic            req_type,
    input  wire logic [3:0][7:0] ref_s,
    input  wire logic [3:0][7:0] cmp_s,
    input  wire logic            q_full,
    output logic                 push,
    output wrm_cmd_t             push_cmd,
    output logic [MAX_CHANNELS*SQ_W-1:0] push_data
);

    logic [POS_W-1:0] inpos_reg, outpos_reg;
    logic [ROW_W-1:0] inrow_reg, outrow_reg;
    logic [COL_W-1:0] incol_reg, outcol_reg;
    logic             pend_reg;
    logic             hold_reg;

    logic             restart_now, fire, drop, emit, in_frame;
    logic [POS_W-1:0] ip, op;
    logic [ROW_W-1:0] ir, orow;
    logic [COL_W-1:0] ic, ocol;
    logic             in_wrap, out_wrap;

    // input is held off after a config write while the new config settles
    assign in_ready = !q_full && !hold_reg;
    assign fire     = in_valid && in_ready;

    // classification of the current request
    always_comb
    begin
        restart_now = (outpos_reg >= cfg.total);
        ip   = restart_now ? '0 : inpos_reg;
        op   = restart_now ? '0 : outpos_reg;
        ir   = restart_now ? '0 : inrow_reg;
        ic   = restart_now ? '0 : incol_reg;
        orow = restart_now ? '0 : outrow_reg;
        ocol = restart_now ? '0 : outcol_reg;
        in_frame = (ip < cfg.total);
        drop     = in_frame && req_type;
        emit     = (ip >= cfg.delay) && ((ip - cfg.delay) == op) && (op < cfg.total);
        in_wrap  = (({1'b0, ic} + (COL_W+1)'(1)) == {1'b0, cfg.width});
        out_wrap = (({1'b0, ocol} + (COL_W+1)'(1)) == {1'b0, cfg.width});
        push     = fire && !drop;
        push_cmd.restart = pend_reg || restart_now;
        push_cmd.emit    = emit;
        push_cmd.last    = ((op + POS_W'(1)) == cfg.total);
        push_cmd.in_row  = ir;
        push_cmd.in_col  = ic;
        push_cmd.out_row = orow;
        push_cmd.out_col = ocol;
    end

    // squared differences of the channels in use
    always_comb
    begin
        logic [7:0] ad;
        push_data = '0;
        for (int c = 0; c < MAX_CHANNELS; c++)
        begin
            ad = (ref_s[c] >= cmp_s[c]) ? (ref_s[c] - cmp_s[c]) : (cmp_s[c] - ref_s[c]);
            if (in_frame && (CHN_W'(c) < cfg.chans))
            begin
                push_data[c*SQ_W +: SQ_W] = SQ_W'(ad) * SQ_W'(ad);
            end
        end
    end

    // position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inpos_reg  <= '0;
            outpos_reg <= '0;
            inrow_reg  <= '0;
            incol_reg  <= '0;
            outrow_reg <= '0;
            outcol_reg <= '0;
            pend_reg   <= 1'b1;
            hold_reg   <= 1'b0;
        end
        else
        begin
            hold_reg <= cfg_wr;
            if (cfg_wr)
            begin
                inpos_reg  <= '0;
                outpos_reg <= '0;
                inrow_reg  <= '0;
                incol_reg  <= '0;
                outrow_reg <= '0;
                outcol_reg <= '0;
                pend_reg   <= 1'b1;
            end
            else if (fire)
            begin
                if (drop)
                begin
                    inpos_reg  <= ip;
                    outpos_reg <= op;
                    inrow_reg  <= ir;
                    incol_reg  <= ic;
                    outrow_reg <= orow;
                    outcol_reg <= ocol;
                    pend_reg   <= pend_reg || restart_now;
                end
                else
                begin
                    pend_reg  <= 1'b0;
                    inpos_reg <= ip + POS_W'(1);
                    incol_reg <= in_wrap ? '0 : ic + COL_W'(1);
                    inrow_reg <= in_wrap ? ir + ROW_W'(1) : ir;
                    if (emit)
                    begin
                        outpos_reg <= op + POS_W'(1);
                        outcol_reg <= out_wrap ? '0 : ocol + COL_W'(1);
                        outrow_reg <= out_wrap ? orow + ROW_W'(1) : orow;
                    end
                    else
                    begin
                        outpos_reg <= op;
                        outcol_reg <= ocol;
                        outrow_reg <= orow;
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

FILE: hdl/wrm_back.sv
// back part: line buffer, window sums, divide, square root, average and maximum
`default_nettype none
module wrm_back import wrm_pkg::*; #(
    parameter int MAX_WIDTH     = 1024,
    parameter int WINDOW_RADIUS = 3,
    parameter int MAX_CHANNELS  = 4
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire wrm_cfg_t cfg,
    input  wire logic     q_empty,
    output logic          q_pop,
    input  wire wrm_cmd_t head_cmd,
    input  wire logic [MAX_CHANNELS*SQ_W-1:0] head_data,
    output logic          out_valid,
    input  wire logic     out_ready,
    output logic [RMSE_W-1:0] rmse_value,
    output logic [9:0]    out_col,
    output logic [11:0]   out_row,
    output logic          frame_last,
    output logic [RMSE_W-1:0] frame_max
);

    localparam int SIDE   = 2 * WINDOW_RADIUS + 1;
    localparam int AREA   = SIDE * SIDE;
    localparam int SLOTS  = 2 * WINDOW_RADIUS;
    localparam int SLOT_W = MAX_CHANNELS * SQ_W;
    localparam int RAM_W  = SLOTS * SLOT_W;
    localparam int RAM_AW = $clog2(MAX_WIDTH);
    localparam int CS_W   = SQ_W + $clog2(SIDE);
    localparam int WS_W   = SQ_W + $clog2(AREA);
    localparam int AREA_W = $clog2(AREA);
    localparam int K      = WS_W + AREA_W;
    localparam int M_W    = K - AREA_W + 1;
    localparam int P_W    = WS_W + M_W;
    localparam longint unsigned RECIP_L = ((64'd1 << K) + AREA - 1) / AREA;
    localparam logic [M_W-1:0] RECIP = M_W'(RECIP_L);
    localparam int ACC_W  = RMSE_W + 2;

    typedef enum logic [3:0] {
        ST_IDLE, ST_COL, ST_HSUM, ST_DIV1, ST_DIV2, ST_DIV3, ST_SQRT, ST_AVG, ST_OUT
    } state_t;

    state_t            state_reg;
    wrm_cmd_t          cmd_reg;
    logic [SLOT_W-1:0] cur_reg;
    logic              cs_val_reg [SIDE];
    logic [ROW_W-1:0]  cs_tag_reg [SIDE];
    logic [CS_W-1:0]   cs_sum_reg [SIDE][MAX_CHANNELS];
    logic [WS_W-1:0]   wsum_reg [MAX_CHANNELS];
    logic [15:0]       quo_reg [MAX_CHANNELS];
    logic [WS_W-1:0]   frac_reg [MAX_CHANNELS];
    logic [31:0]       x_reg [MAX_CHANNELS];
    logic [17:0]       sqrem_reg [MAX_CHANNELS];
    logic [15:0]       root_reg [MAX_CHANNELS];
    logic [3:0]        cnt_reg;
    logic [RMSE_W-1:0] avg_reg;
    logic [RMSE_W-1:0] max_reg;
    logic              out_valid_reg;
    logic [RMSE_W-1:0] out_rmse_reg;
    logic [RMSE_W-1:0] out_max_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic              out_last_reg;

    logic [RAM_W-1:0]  rd_data;
    logic [RAM_W-1:0]  line_next;
    logic              wr_en;
    logic [CS_W-1:0]   colsum_next [MAX_CHANNELS];
    logic [WS_W-1:0]   wsum_next [MAX_CHANNELS];
    logic [15:0]       quo_next [MAX_CHANNELS];
    logic [WS_W-1:0]   frac_next [MAX_CHANNELS];
    logic [31:0]       x_next [MAX_CHANNELS];
    logic [17:0]       sqrem_next [MAX_CHANNELS];
    logic [15:0]       root_next [MAX_CHANNELS];
    logic [RMSE_W-1:0] avg_next;
    logic              load_out;

    // line buffer, one word of stored rows per column
    wrm_ram #(.WIDTH(RAM_W), .DEPTH(MAX_WIDTH)) u_lines (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (RAM_AW'(cmd_reg.in_col)),
        .wr_data (line_next),
        .rd_en   (q_pop),
        .rd_addr (RAM_AW'(head_cmd.in_col)),
        .rd_data (rd_data)
    );

    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;
    assign wr_en    = (state_reg == ST_COL);
    assign load_out = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);

    // newest row enters slot zero, oldest drops out
    generate
        if (SLOTS > 1)
        begin : g_shift
            assign line_next = {rd_data[RAM_W-SLOT_W-1:0], cur_reg};
        end
        else
        begin : g_single
            assign line_next = cur_reg;
        end
    endgenerate

    // vertical column sum with rows outside the frame masked
    always_comb
    begin
        logic row_ok;
        for (int c = 0; c < MAX_CHANNELS; c++)
        begin
            colsum_next[c] = CS_W'(cur_reg[c*SQ_W +: SQ_W]);
        end
        for (int j = 0; j < SLOTS; j++)
        begin
            row_ok = ({1'b0, cmd_reg.in_row} >= (ROW_W+1)'(j + 1)) &&
                     ((cmd_reg.in_row - ROW_W'(j + 1)) < cfg.height);
            for (int c = 0; c < MAX_CHANNELS; c++)
            begin
                if (row_ok)
                begin
                    colsum_next[c] = colsum_next[c] +
                                     CS_W'(rd_data[j*SLOT_W + c*SQ_W +: SQ_W]);
                end
            end
        end
    end

    // horizontal sum over column sums of the same center row
    always_comb
    begin
        logic hit;
        for (int c = 0; c < MAX_CHANNELS; c++)
        begin
            wsum_next[c] = '0;
        end
        for (int k = 0; k < SIDE; k++)
        begin
            hit = cs_val_reg[k] && ({1'b0, cs_tag_reg[k]} ==
                  ({1'b0, cmd_reg.out_row} + (ROW_W+1)'(WINDOW_RADIUS)));
            for (int c = 0; c < MAX_CHANNELS; c++)
            begin
                if (hit)
                begin
                    wsum_next[c] = wsum_next[c] + WS_W'(cs_sum_reg[k][c]);
                end
            end
        end
    end

    // divide by the window area through its reciprocal, square root steps
    always_comb
    begin
        logic [P_W-1:0]  prod;
        logic [WS_W-1:0] rem;
        logic [19:0]     temp;
        logic [19:0]     trial;
        for (int c = 0; c < MAX_CHANNELS; c++)
        begin
            prod         = P_W'(wsum_reg[c]) * P_W'(RECIP);
            quo_next[c]  = prod[K +: 16];
            rem          = wsum_reg[c] - WS_W'(WS_W'(quo_reg[c]) * WS_W'(AREA));
            frac_next[c] = {rem[AREA_W-1:0], 16'd0};
            prod         = P_W'(frac_reg[c]) * P_W'(RECIP);
            x_next[c]    = {quo_reg[c], prod[K +: 16]};
            temp         = {sqrem_reg[c], x_reg[c][31:30]};
            trial        = {2'b00, root_reg[c], 2'b01};
            if (temp >= trial)
            begin
                sqrem_next[c] = 18'(temp - trial);
                root_next[c]  = {root_reg[c][14:0], 1'b1};
            end
            else
            begin
                sqrem_next[c] = temp[17:0];
                root_next[c]  = {root_reg[c][14:0], 1'b0};
            end
        end
    end

    // channel average, unused channels contribute zero
    always_comb
    begin
        logic [ACC_W-1:0]         acc;
        logic [ACC_W+THIRD_W-1:0] third;
        acc = '0;
        for (int c = 0; c < MAX_CHANNELS; c++)
        begin
            acc = acc + ACC_W'(root_reg[c]);
        end
        third = (ACC_W+THIRD_W)'(acc) * (ACC_W+THIRD_W)'(THIRD_MUL);
        unique case (cfg.chans)
            3'd2:    avg_next = RMSE_W'(acc >> 1);
            3'd3:    avg_next = third[THIRD_SHIFT +: RMSE_W];
            3'd4:    avg_next = RMSE_W'(acc >> 2);
            default: avg_next = RMSE_W'(acc);
        endcase
    end

    // sequencer and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            max_reg       <= '0;
            cnt_reg       <= '0;
            for (int k = 0; k < SIDE; k++)
            begin
                cs_val_reg[k] <= 1'b0;
            end
        end
        else
        begin
            if (out_valid_reg && out_ready && !load_out)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        cmd_reg   <= head_cmd;
                        cur_reg   <= head_data;
                        state_reg <= ST_COL;
                    end
                end
                ST_COL:
                begin
                    for (int k = SIDE - 1; k > 0; k--)
                    begin
                        cs_val_reg[k] <= cmd_reg.restart ? 1'b0 : cs_val_reg[k-1];
                        cs_tag_reg[k] <= cs_tag_reg[k-1];
                        cs_sum_reg[k] <= cs_sum_reg[k-1];
                    end
                    cs_val_reg[0] <= 1'b1;
                    cs_tag_reg[0] <= cmd_reg.in_row;
                    cs_sum_reg[0] <= colsum_next;
                    if (cmd_reg.restart)
                    begin
                        max_reg <= '0;
                    end
                    state_reg <= cmd_reg.emit ? ST_HSUM : ST_IDLE;
                end
                ST_HSUM:
                begin
                    wsum_reg  <= wsum_next;
                    state_reg <= ST_DIV1;
                end
                ST_DIV1:
                begin
                    quo_reg   <= quo_next;
                    state_reg <= ST_DIV2;
                end
                ST_DIV2:
                begin
                    frac_reg  <= frac_next;
                    state_reg <= ST_DIV3;
                end
                ST_DIV3:
                begin
                    x_reg   <= x_next;
                    cnt_reg <= '0;
                    for (int c = 0; c < MAX_CHANNELS; c++)
                    begin
                        sqrem_reg[c] <= '0;
                        root_reg[c]  <= '0;
                    end
                    state_reg <= ST_SQRT;
                end
                ST_SQRT:
                begin
                    for (int c = 0; c < MAX_CHANNELS; c++)
                    begin
                        sqrem_reg[c] <= sqrem_next[c];
                        root_reg[c]  <= root_next[c];
                        x_reg[c]     <= {x_reg[c][29:0], 2'b00};
                    end
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd15)
                    begin
                        state_reg <= ST_AVG;
                    end
                end
                ST_AVG:
                begin
                    avg_reg   <= avg_next;
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (load_out)
                    begin
                        out_valid_reg <= 1'b1;
                        out_rmse_reg  <= avg_reg;
                        out_max_reg   <= (avg_reg > max_reg) ? avg_reg : max_reg;
                        max_reg       <= (avg_reg > max_reg) ? avg_reg : max_reg;
                        out_col_reg   <= cmd_reg.out_col;
                        out_row_reg   <= cmd_reg.out_row;
                        out_last_reg  <= cmd_reg.last;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign rmse_value = out_rmse_reg;
    assign frame_max  = out_max_reg;
    assign out_col    = out_col_reg[9:0];
    assign out_row    = out_row_reg[11:0];
    assign frame_last = out_last_reg;

    // a loaded result is shown in the next cycle
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid_reg)
        else $error("result load lost");

    // shown value never exceeds the running maximum shown with it
    a_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_rmse_reg <= out_max_reg))
        else $error("frame maximum below result");

    // a new result only comes from the output step
    a_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside output step");

endmodule
`default_nettype wire

FILE: hdl/windowed_rmse_error_map.sv
// a pixel request is registered into the queue before the back part sees it; a result
// leaves after the request that completes its window (3*width+3 requests later)
// the back part takes a new request only after it is through with the last one; a request
// with result also runs the 16-step square root and the reciprocal divide in the back part
// reset: position counters and running maximum cleared, registers at 640x480x3,
// line buffer contents undefined and masked by row position
`default_nettype none
module windowed_rmse_error_map import wrm_pkg::*; #(
    parameter int MAX_WIDTH     = 1024,
    parameter int WINDOW_RADIUS = 3,
    parameter int MAX_CHANNELS  = 4
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  req_type,
    input  wire logic [7:0]            ref_ch0,
    input  wire logic [7:0]            ref_ch1,
    input  wire logic [7:0]            ref_ch2,
    input  wire logic [7:0]            ref_ch3,
    input  wire logic [7:0]            cmp_ch0,
    input  wire logic [7:0]            cmp_ch1,
    input  wire logic [7:0]            cmp_ch2,
    input  wire logic [7:0]            cmp_ch3,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic      [15:0]           rmse_value,
    output logic      [9:0]            out_col,
    output logic      [11:0]           out_row,
    output logic                       frame_last,
    output logic      [15:0]           frame_max
);

    localparam int DW = MAX_CHANNELS * SQ_W;

    logic [COL_W-1:0] width_reg;
    logic [ROW_W-1:0] height_reg;
    logic [CHN_W-1:0] chans_reg;
    wrm_cfg_t         cfg_reg;
    wrm_cfg_t         cfg_next;
    logic             wr_hit;
    logic             cfg_wr;

    logic             push, pop, q_full, q_empty;
    wrm_cmd_t         push_cmd, head_cmd;
    logic [DW-1:0]    push_data, head_data;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && pready;
    assign cfg_wr = wr_hit && ((paddr[3:2] == REG_WIDTH) || (paddr[3:2] == REG_HEIGHT) ||
                               (paddr[3:2] == REG_CHANNELS));

    // register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= COL_W'(640);
            height_reg <= ROW_W'(480);
            chans_reg  <= CHN_W'(3);
        end
        else if (wr_hit)
        begin
            unique case (paddr[3:2])
                REG_WIDTH:    width_reg  <= pwdata[COL_W-1:0];
                REG_HEIGHT:   height_reg <= pwdata[ROW_W-1:0];
                REG_CHANNELS: chans_reg  <= pwdata[CHN_W-1:0];
                default:      ;
            endcase
        end
    end

    // register read
    always_comb
    begin
        unique case (paddr[3:2])
            REG_WIDTH:    prdata = 32'(width_reg);
            REG_HEIGHT:   prdata = 32'(height_reg);
            REG_CHANNELS: prdata = 32'(chans_reg);
            default:      prdata = '0;
        endcase
    end

    // effective frame configuration with clamping
    always_comb
    begin
        if (width_reg == '0)
        begin
            cfg_next.width = COL_W'(1);
        end
        else if (32'(width_reg) > 32'(MAX_WIDTH))
        begin
            cfg_next.width = COL_W'(MAX_WIDTH);
        end
        else
        begin
            cfg_next.width = width_reg;
        end
        if (height_reg == '0)
        begin
            cfg_next.height = ROW_W'(1);
        end
        else if (height_reg > ROW_W'(4096))
        begin
            cfg_next.height = ROW_W'(4096);
        end
        else
        begin
            cfg_next.height = height_reg;
        end
        if (chans_reg == '0)
        begin
            cfg_next.chans = CHN_W'(1);
        end
        else if (32'(chans_reg) > 32'(MAX_CHANNELS))
        begin
            cfg_next.chans = CHN_W'(MAX_CHANNELS);
        end
        else
        begin
            cfg_next.chans = chans_reg;
        end
        cfg_next.total = POS_W'(cfg_next.width) * POS_W'(cfg_next.height);
        cfg_next.delay = POS_W'(WINDOW_RADIUS) * (POS_W'(cfg_next.width) + POS_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width  <= COL_W'(640);
            cfg_reg.height <= ROW_W'(480);
            cfg_reg.chans  <= CHN_W'(3);
            cfg_reg.total  <= POS_W'(640 * 480);
            cfg_reg.delay  <= POS_W'(WINDOW_RADIUS * 641);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    wrm_front #(.MAX_CHANNELS(MAX_CHANNELS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cfg_wr    (cfg_wr),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .ref_s     ({ref_ch3, ref_ch2, ref_ch1, ref_ch0}),
        .cmp_s     ({cmp_ch3, cmp_ch2, cmp_ch1, cmp_ch0}),
        .q_full    (q_full),
        .push      (push),
        .push_cmd  (push_cmd),
        .push_data (push_data)
    );

    wrm_queue #(.DW(DW)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .empty     (q_empty),
        .head_cmd  (head_cmd),
        .head_data (head_data)
    );

    wrm_back #(
        .MAX_WIDTH     (MAX_WIDTH),
        .WINDOW_RADIUS (WINDOW_RADIUS),
        .MAX_CHANNELS  (MAX_CHANNELS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_empty    (q_empty),
        .q_pop      (pop),
        .head_cmd   (head_cmd),
        .head_data  (head_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .rmse_value (rmse_value),
        .out_col    (out_col),
        .out_row    (out_row),
        .frame_last (frame_last),
        .frame_max  (frame_max)
    );

endmodule
`default_nettype wire
